FILE: sv/bfa_pkg.sv
package bfa_pkg;

  localparam int unsigned FRAME_LIMIT = 1048576;
  localparam int unsigned FRAME_SHIFT = 12;
  localparam int unsigned FW          = $clog2(FRAME_LIMIT) + 1;
  localparam int unsigned MAP_WORDS   = (FRAME_LIMIT + 31) / 32;
  localparam int unsigned WAW         = $clog2(MAP_WORDS);
  localparam int unsigned LOW_FRAMES  = 32'h100000 >> FRAME_SHIFT;
  localparam int unsigned DEF_FRAMES  = (128 * 1024 * 1024) >> FRAME_SHIFT;
  localparam int unsigned MIN_KB      = 1024;
  localparam int unsigned MIN_FRAMES  = (1 << 20) >> FRAME_SHIFT;

  typedef enum logic [2:0] {
    OP_INIT  = 3'd0,
    OP_ALLOC = 3'd1,
    OP_FREE  = 3'd2,
    OP_USE   = 3'd3,
    OP_REL   = 3'd4
  } bfa_op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FRAME = 2'd1,
    ST_MISALIGN = 2'd2
  } bfa_status_e;

  typedef enum logic [1:0] {
    REG_MEM_LOWER = 2'd0,
    REG_MEM_UPPER = 2'd1,
    REG_KSTART    = 2'd2,
    REG_KEND      = 2'd3
  } bfa_reg_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SWEEP,
    S_RD,
    S_MOD,
    S_FIN
  } bfa_state_e;

  typedef enum logic [2:0] {
    M_CLEAR,
    M_INIT,
    M_ALLOC,
    M_USE,
    M_REL
  } bfa_mode_e;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] start_address;
    logic [31:0] end_address;
  } bfa_req_t;

  typedef struct packed {
    logic [31:0]  frame_address;
    bfa_status_e  status;
    logic [20:0]  free_frames;
    logic [20:0]  total_frames;
  } bfa_res_t;

  typedef struct packed {
    bfa_mode_e        mode;
    logic [WAW-1:0]   word;
    logic [FW-1:0]    lo;
    logic [FW-1:0]    hi;
    logic [FW-1:0]    lo2;
    logic [FW-1:0]    hi2;
  } bfa_wctl_t;

  typedef struct packed {
    logic [31:0] wdata;
    logic [5:0]  cnt;
    logic        hit;
    logic [4:0]  idx;
  } bfa_wres_t;

  // bits of word w whose frame lies in [lo, hi)
  function automatic logic [31:0] range_mask(logic [WAW-1:0] w, logic [FW-1:0] lo,
                                             logic [FW-1:0] hi);
    logic [FW-6:0] ww, lw, hw;
    logic [31:0]   lm, um;
    ww = (FW-5)'(w);
    lw = lo[FW-1:5];
    hw = hi[FW-1:5];
    if (ww < lw) lm = '0;
    else if (ww == lw) lm = 32'hffff_ffff << lo[4:0];
    else lm = 32'hffff_ffff;
    if (ww < hw) um = 32'hffff_ffff;
    else if (ww == hw) um = ~(32'hffff_ffff << hi[4:0]);
    else um = '0;
    return lm & um;
  endfunction

  function automatic logic [5:0] popcount(logic [31:0] v);
    logic [5:0] c;
    c = '0;
    for (int i = 0; i < 32; i++) c = c + 6'(v[i]);
    return c;
  endfunction

  // byte address to frame number, held at the frame limit
  function automatic logic [FW-1:0] clip_frame(logic [31:0] a);
    logic [31:0] v;
    v = a >> FRAME_SHIFT;
    if (v > FRAME_LIMIT) v = FRAME_LIMIT;
    return FW'(v);
  endfunction

  // exclusive end address rounded up to a frame, held at the pool size
  function automatic logic [FW-1:0] end_frame(logic [31:0] e, logic [FW-1:0] tot);
    logic [32:0] v;
    v = ({1'b0, e} + 33'((1 << FRAME_SHIFT) - 1)) >> FRAME_SHIFT;
    if (v > 33'(tot)) return tot;
    return FW'(v);
  endfunction

  // pool size in frames from the sum of the memory-size registers
  function automatic logic [FW-1:0] pool_frames(logic [32:0] kb);
    logic [32:0] f;
    if (kb == '0) f = 33'(DEF_FRAMES);
    else if (kb < 33'(MIN_KB)) f = 33'(MIN_FRAMES);
    else f = kb >> 2;
    if (f > 33'(FRAME_LIMIT)) f = 33'(FRAME_LIMIT);
    return FW'(f);
  endfunction

endpackage

FILE: sv/bfa_ram.sv
module bfa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: sv/bfa_word_unit.sv
module bfa_word_unit (
  input  bfa_pkg::bfa_wctl_t ctl_i,
  input  logic [31:0]        rdata_i,
  output bfa_pkg::bfa_wres_t res_o
);

  logic [31:0] m1, m2, avail, onehot;
  logic [4:0]  idx;

  assign m1 = bfa_pkg::range_mask(ctl_i.word, ctl_i.lo, ctl_i.hi);
  assign m2 = bfa_pkg::range_mask(ctl_i.word, ctl_i.lo2, ctl_i.hi2);

  // lowest free frame of the word
  assign avail  = ~rdata_i & m1;
  assign onehot = avail & (~avail + 32'd1);

  always_comb begin
    idx = '0;
    for (int b = 0; b < 32; b++) begin
      if (onehot[b]) idx = idx | 5'(b);
    end
  end

  // modify one map word
  always_comb begin
    res_o = '0;
    unique case (ctl_i.mode)
      bfa_pkg::M_CLEAR: res_o.wdata = '0;
      bfa_pkg::M_INIT: begin
        res_o.wdata = m1 | m2;
        res_o.cnt   = bfa_pkg::popcount(m1 | m2);
      end
      bfa_pkg::M_ALLOC: begin
        res_o.wdata = rdata_i | onehot;
        res_o.hit   = |avail;
        res_o.idx   = idx;
        res_o.cnt   = 6'd1;
      end
      bfa_pkg::M_USE: begin
        res_o.wdata = rdata_i | m1;
        res_o.cnt   = bfa_pkg::popcount(m1 & ~rdata_i);
      end
      bfa_pkg::M_REL: begin
        res_o.wdata = rdata_i & ~m1;
        res_o.cnt   = bfa_pkg::popcount(m1 & rdata_i);
      end
      default: res_o = '0;
    endcase
  end

endmodule

FILE: sv/bitmap_frame_allocator.sv
// channel  direction  handshake                 payload
// in       input      in_valid_i / in_stall_o   in_req_i  (bfa_req_t)
// out      output     out_valid_o / out_stall_i out_res_o (bfa_res_t)
// cfg      input      cfg_we_i                  cfg_index_i, cfg_wdata_i
// one request at a time; the used map is reached one word at a time through one ram port
// init: one write per map word; free, range ops, allocate:
// each word visited is read, then modified and written
// after reset a clearing pass writes all 32768 map words; in_stall_o is high meanwhile
// a result waits in the output register; the next request is taken while it waits
module bitmap_frame_allocator (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  bfa_pkg::bfa_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output bfa_pkg::bfa_res_t out_res_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [31:0]       cfg_wdata_i
);

  localparam int unsigned FW  = bfa_pkg::FW;
  localparam int unsigned WAW = bfa_pkg::WAW;

  bfa_pkg::bfa_state_e state_q, state_d;
  bfa_pkg::bfa_mode_e  mode_q, mode_d;
  logic [WAW-1:0]      w_q, w_d, last_q, last_d;
  logic [FW-1:0]       lo_q, lo_d, hi_q, hi_d, lo2_q, lo2_d, hi2_q, hi2_d;
  logic [FW-1:0]       total_q, total_d, free_q, free_d;
  logic [31:0]         addr_q, addr_d;
  bfa_pkg::bfa_status_e status_q, status_d;
  logic [31:0]         lower_q, upper_q, kstart_q, kend_q;
  logic                out_valid_q;
  bfa_pkg::bfa_res_t   out_q;

  logic                acc, emit, ram_we;
  logic [31:0]         ram_rdata;
  bfa_pkg::bfa_wctl_t  wctl;
  bfa_pkg::bfa_wres_t  wres;
  logic [FW-1:0]       init_total, rng_lo, rng_hi, free_lo, free_hi;
  logic                free_empty, rng_empty, last_word;
  logic [FW:0]         free_up;

  assign in_stall_o = (state_q != bfa_pkg::S_IDLE);
  assign acc        = in_valid_i && !in_stall_o;
  assign emit       = (state_q == bfa_pkg::S_FIN) && !(out_valid_q && out_stall_i);
  assign last_word  = (w_q == last_q);

  // request decode
  assign init_total = bfa_pkg::pool_frames({1'b0, lower_q} + {1'b0, upper_q});
  assign rng_lo     = bfa_pkg::clip_frame(in_req_i.start_address);
  assign rng_hi     = bfa_pkg::end_frame(in_req_i.end_address, total_q);
  assign rng_empty  = (in_req_i.end_address <= in_req_i.start_address) || (rng_lo >= rng_hi);
  assign free_lo    = rng_lo;
  assign free_hi    = (rng_lo + FW'(1) > total_q) ? total_q : rng_lo + FW'(1);
  assign free_empty = (free_lo >= free_hi);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q  <= '0;
      upper_q  <= '0;
      kstart_q <= '0;
      kend_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        bfa_pkg::REG_MEM_LOWER: lower_q  <= cfg_wdata_i;
        bfa_pkg::REG_MEM_UPPER: upper_q  <= cfg_wdata_i;
        bfa_pkg::REG_KSTART:    kstart_q <= cfg_wdata_i;
        bfa_pkg::REG_KEND:      kend_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // map storage
  assign wctl = '{mode: mode_q, word: w_q, lo: lo_q, hi: hi_q, lo2: lo2_q, hi2: hi2_q};

  bfa_word_unit u_word (
    .ctl_i   (wctl),
    .rdata_i (ram_rdata),
    .res_o   (wres)
  );

  assign ram_we = (state_q == bfa_pkg::S_CLEAR) || (state_q == bfa_pkg::S_SWEEP) ||
                  ((state_q == bfa_pkg::S_MOD) &&
                   ((mode_q != bfa_pkg::M_ALLOC) || wres.hit));

  bfa_ram #(
    .WIDTH (32),
    .DEPTH (bfa_pkg::MAP_WORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (w_q),
    .wdata_i (wres.wdata),
    .raddr_i (w_q),
    .rdata_o (ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bfa_pkg::S_CLEAR: if (last_word) state_d = bfa_pkg::S_IDLE;
      bfa_pkg::S_IDLE: begin
        if (acc) begin
          priority case (in_req_i.opcode)
            bfa_pkg::OP_INIT:  state_d = bfa_pkg::S_SWEEP;
            bfa_pkg::OP_ALLOC: state_d = (total_q == '0) ? bfa_pkg::S_FIN : bfa_pkg::S_RD;
            bfa_pkg::OP_FREE: begin
              if (in_req_i.start_address[bfa_pkg::FRAME_SHIFT-1:0] != '0 || free_empty)
                state_d = bfa_pkg::S_FIN;
              else state_d = bfa_pkg::S_RD;
            end
            bfa_pkg::OP_USE, bfa_pkg::OP_REL:
              state_d = rng_empty ? bfa_pkg::S_FIN : bfa_pkg::S_RD;
            default: state_d = bfa_pkg::S_FIN;
          endcase
        end
      end
      bfa_pkg::S_SWEEP: if (last_word) state_d = bfa_pkg::S_FIN;
      bfa_pkg::S_RD:    state_d = bfa_pkg::S_MOD;
      bfa_pkg::S_MOD: begin
        if (((mode_q == bfa_pkg::M_ALLOC) && wres.hit) || last_word) state_d = bfa_pkg::S_FIN;
        else state_d = bfa_pkg::S_RD;
      end
      bfa_pkg::S_FIN: if (emit) state_d = bfa_pkg::S_IDLE;
      default: state_d = bfa_pkg::S_IDLE;
    endcase
  end

  assign free_up = {1'b0, free_q} + (FW+1)'(wres.cnt);

  // datapath updates
  always_comb begin
    mode_d   = mode_q;
    w_d      = w_q;
    last_d   = last_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    lo2_d    = lo2_q;
    hi2_d    = hi2_q;
    total_d  = total_q;
    free_d   = free_q;
    addr_d   = addr_q;
    status_d = status_q;
    unique case (state_q)
      bfa_pkg::S_CLEAR: w_d = w_q + WAW'(1);
      bfa_pkg::S_IDLE: begin
        if (acc) begin
          addr_d   = '0;
          status_d = bfa_pkg::ST_OK;
          lo2_d    = '0;
          hi2_d    = '0;
          priority case (in_req_i.opcode)
            bfa_pkg::OP_INIT: begin
              mode_d  = bfa_pkg::M_INIT;
              total_d = init_total;
              free_d  = init_total;
              lo_d    = '0;
              hi_d    = (init_total < FW'(bfa_pkg::LOW_FRAMES)) ? init_total :
                        FW'(bfa_pkg::LOW_FRAMES);
              lo2_d   = bfa_pkg::clip_frame(kstart_q);
              hi2_d   = bfa_pkg::end_frame(kend_q, init_total);
              w_d     = '0;
              last_d  = WAW'(bfa_pkg::MAP_WORDS - 1);
            end
            bfa_pkg::OP_ALLOC: begin
              mode_d   = bfa_pkg::M_ALLOC;
              status_d = bfa_pkg::ST_NO_FRAME;
              lo_d     = '0;
              hi_d     = total_q;
              w_d      = '0;
              last_d   = WAW'((total_q - FW'(1)) >> 5);
            end
            bfa_pkg::OP_FREE: begin
              mode_d = bfa_pkg::M_REL;
              if (in_req_i.start_address[bfa_pkg::FRAME_SHIFT-1:0] != '0)
                status_d = bfa_pkg::ST_MISALIGN;
              lo_d   = free_lo;
              hi_d   = free_hi;
              w_d    = WAW'(free_lo >> 5);
              last_d = WAW'(free_lo >> 5);
            end
            bfa_pkg::OP_USE, bfa_pkg::OP_REL: begin
              mode_d = (in_req_i.opcode == bfa_pkg::OP_USE) ? bfa_pkg::M_USE : bfa_pkg::M_REL;
              lo_d   = rng_lo;
              hi_d   = rng_hi;
              w_d    = WAW'(rng_lo >> 5);
              last_d = WAW'((rng_hi - FW'(1)) >> 5);
            end
            default: ;
          endcase
        end
      end
      bfa_pkg::S_SWEEP: begin
        free_d = free_q - FW'(wres.cnt);
        w_d    = w_q + WAW'(1);
      end
      bfa_pkg::S_RD: ;
      bfa_pkg::S_MOD: begin
        w_d = w_q + WAW'(1);
        unique case (mode_q)
          bfa_pkg::M_ALLOC: begin
            if (wres.hit) begin
              free_d   = (free_q != '0) ? free_q - FW'(1) : '0;
              status_d = bfa_pkg::ST_OK;
              addr_d   = 32'(64'({w_q, wres.idx}) << bfa_pkg::FRAME_SHIFT);
            end
          end
          bfa_pkg::M_USE: free_d = (free_q > FW'(wres.cnt)) ? free_q - FW'(wres.cnt) : '0;
          bfa_pkg::M_REL: free_d = (free_up > (FW+1)'(bfa_pkg::FRAME_LIMIT)) ?
                                   FW'(bfa_pkg::FRAME_LIMIT) : FW'(free_up);
          default: ;
        endcase
      end
      bfa_pkg::S_FIN: ;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bfa_pkg::S_CLEAR;
      mode_q      <= bfa_pkg::M_CLEAR;
      w_q         <= '0;
      last_q      <= WAW'(bfa_pkg::MAP_WORDS - 1);
      total_q     <= '0;
      free_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      w_q     <= w_d;
      last_q  <= last_d;
      total_q <= total_d;
      free_q  <= free_d;
      if (emit) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    lo2_q    <= lo2_d;
    hi2_q    <= hi2_d;
    addr_q   <= addr_d;
    status_q <= status_d;
    if (emit) begin
      out_q.frame_address <= addr_q;
      out_q.status        <= status_q;
      out_q.free_frames   <= 21'(free_q);
      out_q.total_frames  <= 21'(total_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

`ifndef ASSERT_OFF
  a_free_le_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bfa_pkg::S_IDLE) |-> (free_q <= total_q))
    else $error("free count above pool size");
  a_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == bfa_pkg::S_CLEAR || state_q == bfa_pkg::S_SWEEP ||
                state_q == bfa_pkg::S_MOD))
    else $error("map write outside a write state");
  a_misalign_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == bfa_pkg::ST_MISALIGN) |-> (out_q.frame_address == '0))
    else $error("misaligned free returned an address");
  a_word_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bfa_pkg::S_RD || state_q == bfa_pkg::S_MOD) |-> (w_q <= last_q))
    else $error("word scan past last word");
`endif

endmodule

FILE: tb/tb_bitmap_frame_allocator.sv
`timescale 1ns / 100ps

module tb_bitmap_frame_allocator;

  // opcodes the block leaves without effect
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam int unsigned PAGE_BYTES = 1 << bfa_pkg::FRAME_SHIFT;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  bfa_pkg::bfa_req_t   in_req;
  logic                out_valid;
  logic                out_stall;
  bfa_pkg::bfa_res_t   out_res;
  logic                cfg_we;
  logic [1:0]          cfg_index;
  logic [31:0]         cfg_wdata;

  // model of the allocator
  bit          used_q [bfa_pkg::FRAME_LIMIT];
  int unsigned pool_total;
  int unsigned free_cnt;
  logic [31:0] mem_lower_q, mem_upper_q, kstart_q, kend_q;

  bfa_pkg::bfa_res_t pending_q [$];
  int          mismatches;
  bit          send_idle_en;
  bit          recv_idle_en;
  int          hold_off_cycles;

  bitmap_frame_allocator u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_res_o   (out_res),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("tb_bitmap_frame_allocator failed");
    $finish;
  end

  // exclusive end address to frame, no wrap, clipped to the pool
  function automatic int unsigned last_frame(logic [31:0] e);
    longint unsigned v;
    v = (longint'(e) + PAGE_BYTES - 1) >> bfa_pkg::FRAME_SHIFT;
    if (v > pool_total) v = pool_total;
    return int'(v);
  endfunction

  task automatic rebuild_pool();
    longint unsigned bytes;
    int unsigned     f, lim;
    bytes = (longint'(mem_lower_q) + longint'(mem_upper_q)) * 1024;
    if (mem_lower_q == 0 && mem_upper_q == 0) bytes = 128 * 1024 * 1024;
    if (bytes < (1 << 20)) bytes = 1 << 20;
    bytes = bytes >> bfa_pkg::FRAME_SHIFT;
    if (bytes > bfa_pkg::FRAME_LIMIT) bytes = bfa_pkg::FRAME_LIMIT;
    pool_total = int'(bytes);
    foreach (used_q[i]) used_q[i] = 1'b0;
    lim = bfa_pkg::LOW_FRAMES < pool_total ? bfa_pkg::LOW_FRAMES : pool_total;
    for (f = 0; f < lim; f++) used_q[f] = 1'b1;
    lim = last_frame(kend_q);
    for (f = kstart_q >> bfa_pkg::FRAME_SHIFT; f < lim; f++) used_q[f] = 1'b1;
    free_cnt = 0;
    for (f = 0; f < pool_total; f++) if (!used_q[f]) free_cnt++;
  endtask

  task automatic mark_span(logic [31:0] s, logic [31:0] e, bit set_used);
    int unsigned f, lim;
    if (e <= s) return;
    lim = last_frame(e);
    for (f = s >> bfa_pkg::FRAME_SHIFT; f < lim; f++) begin
      if (set_used && !used_q[f]) begin
        used_q[f] = 1'b1;
        if (free_cnt != 0) free_cnt--;
      end else if (!set_used && used_q[f]) begin
        used_q[f] = 1'b0;
        if (free_cnt < bfa_pkg::FRAME_LIMIT) free_cnt++;
      end
    end
  endtask

  // expected result of one request, updating the model state
  task automatic predict_frame_op(input bfa_pkg::bfa_req_t r, output bfa_pkg::bfa_res_t x);
    int unsigned f;
    x.frame_address = '0;
    x.status = bfa_pkg::ST_OK;
    case (r.opcode)
      bfa_pkg::OP_INIT: rebuild_pool();
      bfa_pkg::OP_ALLOC: begin
        x.status = bfa_pkg::ST_NO_FRAME;
        for (f = 0; f < pool_total; f++) begin
          if (!used_q[f]) begin
            used_q[f] = 1'b1;
            if (free_cnt != 0) free_cnt--;
            x.frame_address = f << bfa_pkg::FRAME_SHIFT;
            x.status = bfa_pkg::ST_OK;
            break;
          end
        end
      end
      bfa_pkg::OP_FREE: begin
        if (r.start_address[bfa_pkg::FRAME_SHIFT-1:0] != '0) begin
          x.status = bfa_pkg::ST_MISALIGN;
        end else begin
          f = r.start_address >> bfa_pkg::FRAME_SHIFT;
          if (f < pool_total && used_q[f]) begin
            used_q[f] = 1'b0;
            if (free_cnt < bfa_pkg::FRAME_LIMIT) free_cnt++;
          end
        end
      end
      bfa_pkg::OP_USE: mark_span(r.start_address, r.end_address, 1'b1);
      bfa_pkg::OP_REL: mark_span(r.start_address, r.end_address, 1'b0);
      default: ;
    endcase
    x.free_frames = free_cnt[20:0];
    x.total_frames = pool_total[20:0];
  endtask

  // offer one request, with an optional gap, and wait for it to be taken
  task automatic send_req(logic [2:0] op, logic [31:0] sa, logic [31:0] ea);
    bfa_pkg::bfa_req_t r;
    bfa_pkg::bfa_res_t x;
    r.opcode = op;
    r.start_address = sa;
    r.end_address = ea;
    if (send_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (in_stall);
    predict_frame_op(r, x);
    pending_q.push_back(x);
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain();
    in_valid <= 1'b0;
    wait (pending_q.size() == 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_regs(logic [31:0] lower, logic [31:0] upper,
                            logic [31:0] ks, logic [31:0] ke);
    logic [31:0] vals [4];
    vals = '{lower, upper, ks, ke};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 2'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    mem_lower_q = lower;
    mem_upper_q = upper;
    kstart_q = ks;
    kend_q = ke;
  endtask

  // receiver side stall pattern
  initial begin
    int burst;
    burst = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        out_stall <= 1'b1;
      end else if (burst > 0) begin
        burst--;
        out_stall <= 1'b1;
      end else if (recv_idle_en && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(0, 6);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // compare each result with the oldest expectation
  initial begin
    bfa_pkg::bfa_res_t x;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        if (pending_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_res);
        end else begin
          x = pending_q.pop_front();
          if (out_res.frame_address !== x.frame_address || out_res.status !== x.status ||
              out_res.free_frames !== x.free_frames ||
              out_res.total_frames !== x.total_frames) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p, got %p", x, out_res);
          end
        end
      end
    end
  end

  task automatic test_before_init();
    send_req(bfa_pkg::OP_ALLOC, '0, '0);
    send_req(bfa_pkg::OP_FREE, 32'h0000_1000, '0);
    send_req(bfa_pkg::OP_USE, '0, 32'hffff_ffff);
    send_req(bfa_pkg::OP_REL, '0, 32'hffff_ffff);
    for (logic [3:0] op = OP_SPARE_LO; op <= OP_SPARE_HI; op++)
      send_req(op[2:0], 32'hffff_ffff, 32'hffff_ffff);
    drain();
  endtask

  // default 128 MiB pool with a small kernel
  task automatic test_default_pool();
    write_regs('0, '0, 32'h0010_0000, 32'h0010_2001);
    send_req(bfa_pkg::OP_INIT, '0, '0);
    send_req(bfa_pkg::OP_ALLOC, '0, '0);
    send_req(bfa_pkg::OP_ALLOC, '0, '0);
    send_req(bfa_pkg::OP_FREE, 32'h0010_4001, '0);
    send_req(bfa_pkg::OP_FREE, 32'h0010_3000, '0);
    send_req(bfa_pkg::OP_FREE, 32'h0010_3000, '0);
    send_req(bfa_pkg::OP_FREE, 32'hffff_f000, '0);
    send_req(bfa_pkg::OP_USE, 32'h0020_0000, 32'h0020_0000);
    send_req(bfa_pkg::OP_USE, 32'h0020_5000, 32'h0020_0000);
    send_req(bfa_pkg::OP_USE, 32'h0020_0fff, 32'h0020_3001);
    send_req(bfa_pkg::OP_REL, 32'h0020_1000, 32'h0020_2000);
    send_req(bfa_pkg::OP_USE, 32'h07ff_e000, 32'hffff_ffff);
    send_req(bfa_pkg::OP_REL, 32'hffff_f000, 32'hffff_ffff);
    drain();
  endtask

  // smallest pool: everything reserved, frame zero handed out
  task automatic test_min_pool();
    write_regs(32'd1, '0, 32'hffff_f000, 32'h0000_0010);
    send_req(bfa_pkg::OP_INIT, '0, '0);
    send_req(bfa_pkg::OP_ALLOC, '0, '0);
    send_req(bfa_pkg::OP_FREE, '0, '0);
    send_req(bfa_pkg::OP_ALLOC, '0, '0);
    send_req(bfa_pkg::OP_REL, '0, 32'h0000_3000);
    send_req(bfa_pkg::OP_USE, '0, 32'hffff_ffff);
    drain();
  endtask

  // largest pool, kernel over the whole of it
  task automatic test_max_pool();
    write_regs(32'hffff_ffff, 32'hffff_ffff, '0, 32'hffff_ffff);
    send_req(bfa_pkg::OP_INIT, '0, '0);
    send_req(bfa_pkg::OP_ALLOC, '0, '0);
    send_req(bfa_pkg::OP_REL, 32'hfff0_0000, 32'hfff0_4000);
    send_req(bfa_pkg::OP_ALLOC, '0, '0);
    send_req(bfa_pkg::OP_FREE, 32'hffff_f000, '0);
    drain();
  endtask

  // long receiver hold-off while requests keep coming
  task automatic test_backpressure();
    write_regs(32'd640, 32'd15360, 32'h0010_0000, 32'h0018_0000);
    send_req(bfa_pkg::OP_INIT, '0, '0);
    drain();
    hold_off_cycles = 400;
    for (int i = 0; i < 8; i++) send_req(bfa_pkg::OP_ALLOC, '0, '0);
    drain();
  endtask

  task automatic test_random(int n_items, bit no_idle);
    logic [31:0] sa, ea;
    int unsigned f, pick;
    write_regs($urandom_range(0, 639), $urandom_range(0, 65536),
               $urandom_range(0, 32'h0080_0000), $urandom_range(0, 32'h0090_0000));
    if (no_idle) begin
      send_idle_en = 1'b0;
      recv_idle_en = 1'b0;
    end
    send_req(bfa_pkg::OP_INIT, '0, '0);
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(0, 99);
      f = $urandom_range(0, pool_total + 16);
      sa = f << bfa_pkg::FRAME_SHIFT;
      if (pick < 30) begin
        send_req(bfa_pkg::OP_ALLOC, $urandom, $urandom);
      end else if (pick < 55) begin
        if ($urandom_range(0, 7) == 0) sa = $urandom;
        send_req(bfa_pkg::OP_FREE, sa, $urandom);
      end else if (pick < 94) begin
        if ($urandom_range(0, 5) == 0) sa = $urandom;
        else sa = sa | $urandom_range(0, PAGE_BYTES - 1);
        if ($urandom_range(0, 9) == 0) ea = $urandom;
        else ea = sa + $urandom_range(0, 40 * PAGE_BYTES);
        if (ea > sa && ea - sa > 32'h0010_0000) ea = sa + 32'h0010_0000;
        send_req(pick < 75 ? bfa_pkg::OP_USE : bfa_pkg::OP_REL, sa, ea);
      end else if (pick < 98) begin
        send_req(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), $urandom, $urandom);
      end else begin
        send_req(bfa_pkg::OP_INIT, $urandom, $urandom);
      end
    end
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    mismatches = 0;
    send_idle_en = 1'b1;
    recv_idle_en = 1'b1;
    hold_off_cycles = 0;
    pool_total = 0;
    free_cnt = 0;
    mem_lower_q = '0;
    mem_upper_q = '0;
    kstart_q = '0;
    kend_q = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_before_init();
    test_default_pool();
    test_min_pool();
    test_max_pool();
    test_backpressure();
    for (int p = 0; p < 5; p++) test_random(105, p == 4);

    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("tb_bitmap_frame_allocator passed");
    end else begin
      $display("tb_bitmap_frame_allocator failed");
    end
    $finish;
  end

endmodule
